// ----- sv/blma_pkg.sv -----
`default_nettype none

package blma_pkg;

   localparam int ADC_W = 12;
   localparam int MV_W  = 13;
   localparam int PCT_W = 7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   typedef logic [ADC_W-1:0] adc_type;
   typedef logic [MV_W-1:0]  mv_type;
   typedef logic [PCT_W-1:0] pct_type;

   localparam mv_type OFFSET_RESET = MV_W'(350);

   localparam mv_type MV_STEP_0 = MV_W'(3600);
   localparam mv_type MV_STEP_1 = MV_W'(3700);
   localparam mv_type MV_STEP_2 = MV_W'(3800);
   localparam mv_type MV_STEP_3 = MV_W'(3900);
   localparam mv_type MV_STEP_4 = MV_W'(4000);
   localparam mv_type MV_STEP_5 = MV_W'(4100);
   localparam mv_type MV_STEP_6 = MV_W'(4200);

   localparam pct_type PCT_LEVEL_0 = PCT_W'(5);
   localparam pct_type PCT_LEVEL_1 = PCT_W'(10);
   localparam pct_type PCT_LEVEL_2 = PCT_W'(30);
   localparam pct_type PCT_LEVEL_3 = PCT_W'(60);
   localparam pct_type PCT_LEVEL_4 = PCT_W'(70);
   localparam pct_type PCT_LEVEL_5 = PCT_W'(85);
   localparam pct_type PCT_LEVEL_6 = PCT_W'(95);
   localparam pct_type PCT_LEVEL_7 = PCT_W'(100);

   function automatic pct_type step_percent(mv_type mv);
      pct_type pct;
      if (mv < MV_STEP_0) begin
         pct = PCT_LEVEL_0;
      end else if (mv < MV_STEP_1) begin
         pct = PCT_LEVEL_1;
      end else if (mv < MV_STEP_2) begin
         pct = PCT_LEVEL_2;
      end else if (mv < MV_STEP_3) begin
         pct = PCT_LEVEL_3;
      end else if (mv < MV_STEP_4) begin
         pct = PCT_LEVEL_4;
      end else if (mv < MV_STEP_5) begin
         pct = PCT_LEVEL_5;
      end else if (mv < MV_STEP_6) begin
         pct = PCT_LEVEL_6;
      end else begin
         pct = PCT_LEVEL_7;
      end
      return pct;
   endfunction

endpackage

`default_nettype wire

// ----- sv/blma_ram.sv -----
`default_nettype none

module blma_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/battery_level_moving_average.sv -----
`default_nettype none

// Moving average of battery voltage. Each req transaction carries one 12-bit converter
// sample; the block doubles it, subtracts the offset held in the csr register (clamping at
// zero) and keeps the last AVG_LEN corrected values in a ring RAM with a running sum. Every
// sample yields one rsp transaction with the rounded window average in millivolts and a
// stepped charge percentage. The oldest value counts as zero until the ring has wrapped, so
// averages are low until AVG_LEN samples have gone in. One sample is taken per clock unless
// the response side stalls. The sum is registered, then the reciprocal multiply and
// threshold compare. The ring RAM's registered read is addressed with the next slot, which
// keeps the rate at one per cycle. Write the offset only while no samples are in flight.
module battery_level_moving_average #(
   parameter int AVG_LEN = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [blma_pkg::REQ_DATA_W-1:0]     req_tdata,  // [11:0] adc_sample
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [blma_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [12:0] avg_millivolts,
                                                                // [19:13] charge_percent
   input  wire logic                                csr_we,
   input  wire logic [blma_pkg::MV_W-1:0]           csr_wdata
);

   import blma_pkg::*;

   localparam int SLOT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
   localparam int SUM_W  = $clog2(8191 * AVG_LEN + 1);
   localparam int NUM_W  = $clog2(8192 * AVG_LEN);
   localparam int LEN_LOG = $clog2(AVG_LEN);
   localparam int K       = NUM_W + LEN_LOG;
   localparam longint RECIP_VAL = ((64'd1 << K) + longint'(AVG_LEN) - 1) / longint'(AVG_LEN);
   localparam logic [K:0] RECIP = (K+1)'(RECIP_VAL);
   localparam logic [NUM_W-1:0] HALF = NUM_W'(AVG_LEN / 2);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_LEN - 1);

   mv_type              offset_ff;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic                wrap_ff, wrap_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                mid_valid_ff, mid_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   mv_type              avg_ff, avg_in;
   pct_type             pct_ff, pct_in;
   logic                bypass_ff;
   mv_type              bypass_data_ff;

   logic                accept;
   logic                rsp_free;
   logic                rsp_load;
   adc_type             adc;
   mv_type              doubled;
   mv_type              corrected;
   mv_type              ring_rd;
   mv_type              oldest;
   logic [SUM_W:0]      sum_wide;
   logic [NUM_W-1:0]    num;
   logic [NUM_W+K:0]    prod;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !mid_valid_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = mid_valid_ff && rsp_free;

   assign adc     = req_tdata[ADC_W-1:0];
   assign doubled = {adc, 1'b0};

   always_comb begin
      if (offset_ff >= doubled) begin
         corrected = '0;
      end else begin
         corrected = doubled - offset_ff;
      end
   end

   blma_ram #(
      .WIDTH(MV_W),
      .DEPTH(AVG_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (corrected),
      .rd_addr (slot_in),
      .rd_data (ring_rd)
   );

   always_comb begin
      if (!wrap_ff) begin
         oldest = '0;
      end else if (bypass_ff) begin
         oldest = bypass_data_ff;
      end else begin
         oldest = ring_rd;
      end
   end

   always_comb begin
      slot_in  = slot_ff;
      wrap_in  = wrap_ff;
      sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(corrected) - (SUM_W+1)'(oldest);
      sum_in   = sum_ff;
      if (accept) begin
         sum_in = sum_wide[SUM_W-1:0];
         if (slot_ff == LAST_SLOT) begin
            slot_in = '0;
            wrap_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
   end

   assign num    = NUM_W'(sum_ff) + HALF;
   assign prod   = (NUM_W+K+1)'(num) * (NUM_W+K+1)'(RECIP);
   assign avg_in = prod[K +: MV_W];
   assign pct_in = step_percent(avg_in);

   assign mid_valid_in = accept || (mid_valid_ff && !rsp_free);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_RESET;
         slot_ff      <= '0;
         wrap_ff      <= 1'b0;
         sum_ff       <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            offset_ff <= csr_wdata;
         end
         slot_ff      <= slot_in;
         wrap_ff      <= wrap_in;
         sum_ff       <= sum_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bypass_ff    <= accept && (slot_ff == slot_in);
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= corrected;
      if (rsp_load) begin
         avg_ff <= avg_in;
         pct_ff <= pct_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - MV_W - PCT_W)'(0), pct_ff, avg_ff};

endmodule

`default_nettype wire
